// ----- rtl/core/dtfp_pkg.sv -----
package dtfp_pkg;

    // Most digits that each accumulator takes.
    localparam int MAX_DIGITS = 7;
    // The result is scaled to units of 1e-7.
    localparam int SCALE_DIGITS = 7;
    // Accumulator width: holds 10**MAX_DIGITS - 1.
    localparam int ACC_W = 24;
    // Result width.
    localparam int VALUE_W = 48;
    // Width of a digit count, which saturates at its all-ones value.
    localparam int COUNT_W = 4;
    // Width of a configuration register and of the shift into the scale table.
    localparam int LIM_W = 3;
    // Value of both digit limits after reset.
    localparam int LIMIT_RESET = 7;

    // Configuration register indexes.
    localparam logic REG_INT_LIMIT  = 1'b0;
    localparam logic REG_FRAC_LIMIT = 1'b1;

    // Status codes of a result; a form error keeps its own code.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_LEADING_DOT = 3'd1;
    localparam logic [2:0] ST_BAD_FORM    = 3'd2;
    localparam logic [2:0] ST_EMPTY       = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd4;
    localparam logic [2:0] ST_TOO_PRECISE = 3'd5;

    // Characters with a meaning to the parser.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Snapshot of a finished field, handed from the parser to the scaler.
    typedef struct packed {
        logic              negative;
        logic [ACC_W-1:0]  int_acc;
        logic [ACC_W-1:0]  frac_acc;
        logic [LIM_W-1:0]  frac_shift;
        logic [2:0]        status;
    } t_fin;

    // Powers of ten used to align the fraction digits.
    function automatic logic [ACC_W-1:0] pow_ten(input logic [LIM_W-1:0] k);
        logic [ACC_W-1:0] p;
        begin
            case (k)
                3'd0:    p = 24'd1;
                3'd1:    p = 24'd10;
                3'd2:    p = 24'd100;
                3'd3:    p = 24'd1000;
                3'd4:    p = 24'd10000;
                3'd5:    p = 24'd100000;
                3'd6:    p = 24'd1000000;
                default: p = 24'd10000000;
            endcase
            return p;
        end
    endfunction

endpackage

// ----- rtl/core/dtfp_char_if.sv -----
interface dtfp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source(output valid, output char_code, input ready);
    modport sink(input valid, input char_code, output ready);
endinterface

// ----- rtl/core/dtfp_result_if.sv -----
interface dtfp_result_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] fixed_value;
    logic [2:0]         status;

    modport source(output valid, output fixed_value, output status, input ready);
    modport sink(input valid, input fixed_value, input status, output ready);
endinterface

// ----- rtl/core/dtfp_parse.sv -----
module dtfp_parse
    import dtfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic             i_load,
    input  logic [7:0]       i_char,
    input  logic [LIM_W-1:0] i_int_limit,
    input  logic [LIM_W-1:0] i_frac_limit,
    output t_fin             o_fin,
    output logic             o_fin_valid
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_SIGN  = 3'd1;
    localparam logic [2:0] PH_INT   = 3'd2;
    localparam logic [2:0] PH_DOT   = 3'd3;
    localparam logic [2:0] PH_FRAC  = 3'd4;

    localparam logic [1:0] FE_NONE        = 2'd0;
    localparam logic [1:0] FE_LEADING_DOT = 2'd1;
    localparam logic [1:0] FE_BAD         = 2'd2;

    localparam logic [COUNT_W-1:0] CNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] CNT_DIGIT = COUNT_W'(MAX_DIGITS);
    localparam logic [COUNT_W-1:0] CNT_SCALE = COUNT_W'(SCALE_DIGITS);

    logic [2:0]         r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [ACC_W-1:0]   r_iacc, n_iacc;
    logic [ACC_W-1:0]   r_facc, n_facc;
    logic [COUNT_W-1:0] r_icnt, n_icnt;
    logic [COUNT_W-1:0] r_fcnt, n_fcnt;
    logic               r_any, n_any;
    logic [1:0]         r_ferr, n_ferr;
    t_fin               r_fin, n_fin;
    logic               r_fin_valid;

    logic               is_digit;
    logic [3:0]         digit;
    logic [ACC_W-1:0]   iacc_step, facc_step;
    logic [COUNT_W-1:0] icnt_step, fcnt_step;
    logic [1:0]         fe_final;
    logic [COUNT_W-1:0] int_lim, frac_lim;
    logic [2:0]         status;

    assign is_digit = i_char inside {[CH_ZERO:CH_NINE]};
    assign digit    = 4'(i_char - CH_ZERO);

    // Digit step: shift-add times ten, only while the accumulator has room.
    assign iacc_step = (r_icnt < CNT_DIGIT)
                     ? (r_iacc << 3) + (r_iacc << 1) + ACC_W'(digit) : r_iacc;
    assign facc_step = (r_fcnt < CNT_DIGIT)
                     ? (r_facc << 3) + (r_facc << 1) + ACC_W'(digit) : r_facc;
    assign icnt_step = (r_icnt != CNT_MAX) ? r_icnt + 1'b1 : r_icnt;
    assign fcnt_step = (r_fcnt != CNT_MAX) ? r_fcnt + 1'b1 : r_fcnt;

    // Effective limits, capped at the accumulator depth and the scale.
    always_comb begin
        int_lim = COUNT_W'(i_int_limit);
        if (int_lim > CNT_DIGIT) int_lim = CNT_DIGIT;
        frac_lim = COUNT_W'(i_frac_limit);
        if (frac_lim > CNT_DIGIT) frac_lim = CNT_DIGIT;
        if (frac_lim > CNT_SCALE) frac_lim = CNT_SCALE;
    end

    // Ranked status of the field as it stands; a trailing dot is bad form.
    always_comb begin
        fe_final = r_ferr;
        if (r_ferr == FE_NONE && r_phase == PH_DOT) fe_final = FE_BAD;
        if (fe_final != FE_NONE)   status = {1'b0, fe_final};
        else if (!r_any)           status = ST_EMPTY;
        else if (r_icnt > int_lim) status = ST_TOO_LARGE;
        else if (r_fcnt > frac_lim) status = ST_TOO_PRECISE;
        else                       status = ST_OK;
    end

    // Snapshot for the scaler; the value is zero on any error.
    always_comb begin
        n_fin.negative   = r_neg;
        n_fin.int_acc    = (status == ST_OK) ? r_iacc : '0;
        n_fin.frac_acc   = (status == ST_OK) ? r_facc : '0;
        n_fin.frac_shift = LIM_W'(CNT_SCALE - r_fcnt);
        n_fin.status     = status;
    end

    // Field parser: one character per accepted item.
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_iacc  = r_iacc;
        n_facc  = r_facc;
        n_icnt  = r_icnt;
        n_fcnt  = r_fcnt;
        n_any   = r_any;
        n_ferr  = r_ferr;
        if (i_take) begin
            if (i_char != CH_NUL) begin
                n_any = 1'b1;
                if (r_ferr == FE_NONE) begin
                    case (r_phase)
                        PH_START, PH_SIGN: begin
                            if (r_phase == PH_START
                                && (i_char == CH_PLUS || i_char == CH_MINUS)) begin
                                n_neg   = (i_char == CH_MINUS);
                                n_phase = PH_SIGN;
                            end else if (i_char == CH_DOT) begin
                                n_ferr = FE_LEADING_DOT;
                            end else if (is_digit) begin
                                n_iacc  = iacc_step;
                                n_icnt  = icnt_step;
                                n_phase = PH_INT;
                            end else begin
                                n_ferr = FE_BAD;
                            end
                        end
                        PH_INT: begin
                            if (is_digit) begin
                                n_iacc = iacc_step;
                                n_icnt = icnt_step;
                            end else if (i_char == CH_DOT) begin
                                n_phase = PH_DOT;
                            end else begin
                                n_ferr = FE_BAD;
                            end
                        end
                        default: begin
                            if (is_digit) begin
                                n_facc  = facc_step;
                                n_fcnt  = fcnt_step;
                                n_phase = PH_FRAC;
                            end else begin
                                n_ferr = FE_BAD;
                            end
                        end
                    endcase
                end
            end else begin
                // End of field: start over for the next one.
                n_phase = PH_START;
                n_neg   = 1'b0;
                n_iacc  = '0;
                n_facc  = '0;
                n_icnt  = '0;
                n_fcnt  = '0;
                n_any   = 1'b0;
                n_ferr  = FE_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_neg       <= 1'b0;
            r_iacc      <= '0;
            r_facc      <= '0;
            r_icnt      <= '0;
            r_fcnt      <= '0;
            r_any       <= 1'b0;
            r_ferr      <= FE_NONE;
            r_fin_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_iacc  <= n_iacc;
            r_facc  <= n_facc;
            r_icnt  <= n_icnt;
            r_fcnt  <= n_fcnt;
            r_any   <= n_any;
            r_ferr  <= n_ferr;
            if (i_load) begin
                r_fin_valid <= i_take && (i_char == CH_NUL);
            end
        end
    end

    // Snapshot payload register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fin <= n_fin;
        end
    end

    assign o_fin       = r_fin;
    assign o_fin_valid = r_fin_valid;

endmodule

// ----- rtl/core/dtfp_scale.sv -----
module dtfp_scale
    import dtfp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_fin                      i_fin,
    input  logic                      i_fin_valid,
    input  logic                      i_ready,
    output logic                      o_take,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_fixed_value,
    output logic [2:0]                o_status
);

    localparam logic [ACC_W-1:0] UNIT = ACC_W'(10 ** SCALE_DIGITS);

    logic                      r_b_valid;
    logic [VALUE_W-1:0]        r_p_int, n_p_int;
    logic [VALUE_W-1:0]        r_p_frac, n_p_frac;
    logic                      r_b_neg;
    logic [2:0]                r_b_status;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [2:0]                r_status;

    logic                      en_out, en_b;
    logic [VALUE_W-1:0]        mag;

    // Each stage moves on when the stage after it is empty or moving.
    assign en_out = !r_out_valid || i_ready;
    assign en_b   = !r_b_valid || en_out;
    assign o_take = !i_fin_valid || en_b;

    // Product stage: integer part and aligned fraction part.
    assign n_p_int  = i_fin.int_acc * UNIT;
    assign n_p_frac = i_fin.frac_acc * pow_ten(i_fin.frac_shift);

    // Sum stage with sign applied.
    assign mag     = r_p_int + r_p_frac;
    assign n_value = r_b_neg ? $signed(-mag) : $signed(mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_b) begin
                r_b_valid <= i_fin_valid;
            end
            if (en_out) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_p_int    <= n_p_int;
            r_p_frac   <= n_p_frac;
            r_b_neg    <= i_fin.negative;
            r_b_status <= i_fin.status;
        end
        if (en_out) begin
            r_value  <= n_value;
            r_status <= r_b_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_fixed_value = r_value;
    assign o_status      = r_status;

endmodule

// ----- rtl/core/decimal_text_to_fixed_point.sv -----
// Decimal text to fixed point converter.
// Characters arrive on i_char, one per item, valid/ready; a NUL ends the field.
// An optional sign, integer digits, and an optional dot with fraction digits
// form a field. Each finished field yields one item on o_result: the value in
// units of 1e-7 (zero on error) and a status code ranked as form error,
// empty field, too many integer digits, too many fraction digits.
// The user must write the two digit limits on the i_cfg_* port while the block
// is idle; the block itself does not enforce this. Throughput is one character
// per cycle while i_char.ready is high. Each result passes through a
// snapshot register, a product register (two 24x24 multipliers) and the result
// register. When the receiver holds ready low, the three stages fill and
// i_char.ready drops only once the snapshot stage cannot move on; characters
// that end no field keep flowing as long as that stage can load.
// Synchronous reset clears the field state and all valid flags, and sets both
// digit limits to seven.
module decimal_text_to_fixed_point
    import dtfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [LIM_W-1:0] i_cfg_data,
    dtfp_char_if.sink        i_char,
    dtfp_result_if.source    o_result
);

    logic [LIM_W-1:0] r_int_limit;
    logic [LIM_W-1:0] r_frac_limit;
    logic             load;
    logic             take;
    t_fin             fin;
    logic             fin_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_limit  <= LIM_W'(LIMIT_RESET);
            r_frac_limit <= LIM_W'(LIMIT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INT_LIMIT:  r_int_limit  <= i_cfg_data;
                REG_FRAC_LIMIT: r_frac_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_char.ready = load;
    assign take         = i_char.valid && load;

    dtfp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_load       (load),
        .i_char       (i_char.char_code),
        .i_int_limit  (r_int_limit),
        .i_frac_limit (r_frac_limit),
        .o_fin        (fin),
        .o_fin_valid  (fin_valid)
    );

    dtfp_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fin         (fin),
        .i_fin_valid   (fin_valid),
        .i_ready       (o_result.ready),
        .o_take        (load),
        .o_valid       (o_result.valid),
        .o_fixed_value (o_result.fixed_value),
        .o_status      (o_result.status)
    );

endmodule

// ----- dv/tb.sv -----
module tb
    import dtfp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CHARS = 1150;
    localparam int PHASES       = 6;

    typedef enum logic [2:0] {
        AT_START,
        AFTER_SIGN,
        IN_INT,
        AFTER_DOT,
        IN_FRAC
    } t_parse_phase;

    // Tracks the field being parsed and holds the results that must come out.
    class fixed_point_scoreboard;
        logic [2:0]         int_limit;
        logic [2:0]         frac_limit;
        t_parse_phase       phase;
        logic               negative;
        logic [ACC_W-1:0]   int_acc;
        logic [ACC_W-1:0]   frac_acc;
        logic [3:0]         int_count;
        logic [3:0]         frac_count;
        logic [4:0]         char_count;
        logic [2:0]         form_err;
        logic signed [47:0] expected_value[$];
        logic [2:0]         expected_status[$];
        int                 mismatches;

        function new();
            int_limit  = 3'd7;
            frac_limit = 3'd7;
            mismatches = 0;
            clear_field();
        endfunction

        function void clear_field();
            phase      = AT_START;
            negative   = 1'b0;
            int_acc    = '0;
            frac_acc   = '0;
            int_count  = '0;
            frac_count = '0;
            char_count = '0;
            form_err   = ST_OK;
        endfunction

        // Digits past the accumulator's capacity are counted but not added.
        function logic [ACC_W-1:0] shift_digit(logic [ACC_W-1:0] acc, logic [3:0] cnt,
                                               logic [3:0] d);
            return (cnt < MAX_DIGITS) ? acc * 24'd10 + d : acc;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch: %s", $realtime, what);
        endfunction

        // Advances the field on one accepted character; a NUL closes it.
        function void note_char(logic [7:0] c);
            logic               is_digit;
            logic [3:0]         d;
            logic [2:0]         status;
            logic [63:0]        mag;
            logic [63:0]        scale;
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            d = 4'(c - CH_ZERO);
            if (c != CH_NUL) begin
                if (char_count != 5'd31)
                    char_count++;
                if (form_err != ST_OK)
                    return;
                case (phase)
                    AT_START, AFTER_SIGN: begin
                        if (phase == AT_START && (c == CH_PLUS || c == CH_MINUS)) begin
                            negative = (c == CH_MINUS);
                            phase = AFTER_SIGN;
                        end else if (c == CH_DOT) begin
                            form_err = ST_LEADING_DOT;
                        end else if (is_digit) begin
                            int_acc = shift_digit(int_acc, int_count, d);
                            if (int_count != 4'hF)
                                int_count++;
                            phase = IN_INT;
                        end else begin
                            form_err = ST_BAD_FORM;
                        end
                    end
                    IN_INT: begin
                        if (is_digit) begin
                            int_acc = shift_digit(int_acc, int_count, d);
                            if (int_count != 4'hF)
                                int_count++;
                        end else if (c == CH_DOT) begin
                            phase = AFTER_DOT;
                        end else begin
                            form_err = ST_BAD_FORM;
                        end
                    end
                    default: begin
                        if (is_digit) begin
                            frac_acc = shift_digit(frac_acc, frac_count, d);
                            if (frac_count != 4'hF)
                                frac_count++;
                            phase = IN_FRAC;
                        end else begin
                            form_err = ST_BAD_FORM;
                        end
                    end
                endcase
                return;
            end

            // A dot with nothing after it is bad form.
            if (form_err == ST_OK && phase == AFTER_DOT)
                form_err = ST_BAD_FORM;
            if (form_err != ST_OK)
                status = form_err;
            else if (char_count == 0)
                status = ST_EMPTY;
            else if (int_count > int_limit)
                status = ST_TOO_LARGE;
            else if (frac_count > frac_limit)
                status = ST_TOO_PRECISE;
            else
                status = ST_OK;

            mag = '0;
            if (status == ST_OK) begin
                scale = 64'd1;
                for (int k = int'(frac_count); k < SCALE_DIGITS; k++)
                    scale = scale * 64'd10;
                mag = 64'(int_acc) * 64'd10000000 + 64'(frac_acc) * scale;
                if (negative)
                    mag = -mag;
            end
            expected_value.push_back(mag[47:0]);
            expected_status.push_back(status);
            clear_field();
        endfunction

        // Compares one result with the oldest expectation.
        function void check_result(logic signed [47:0] value, logic [2:0] status);
            logic signed [47:0] exp_value;
            logic [2:0]         exp_status;
            if (expected_status.size() == 0) begin
                report($sformatf("unexpected result value %0d status %0d", value, status));
                return;
            end
            exp_value  = expected_value.pop_front();
            exp_status = expected_status.pop_front();
            if (status !== exp_status)
                report($sformatf("status expected %0d got %0d", exp_status, status));
            if (value !== exp_value)
                report($sformatf("fixed_value expected %0d got %0d", exp_value, value));
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [LIM_W-1:0] i_cfg_data;

    dtfp_char_if   chr();
    dtfp_result_if res();

    decimal_text_to_fixed_point dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (chr),
        .o_result    (res)
    );

    fixed_point_scoreboard sb = new();

    // While set, neither side idles.
    bit steady = 1'b0;
    int sent_chars = 0;
    logic [7:0] text[$];

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic bit stall_roll();
        return !steady && ($urandom_range(0, 99) < 29);
    endfunction

    // The receiver stalls at random.
    always @(negedge i_clk) begin
        res.ready <= !stall_roll();
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            sb.check_result(res.fixed_value, res.status);
    end

    // Offers one character, starting at a falling edge and returning at one.
    task automatic send_char(input logic [7:0] c);
        while (stall_roll()) begin
            chr.valid <= 1'b0;
            @(negedge i_clk);
        end
        chr.valid     <= 1'b1;
        chr.char_code <= c;
        do
            @(posedge i_clk);
        while (!chr.ready);
        sb.note_char(c);
        sent_chars++;
        @(negedge i_clk);
    endtask

    // Sends the queued text followed by the closing NUL.
    task automatic send_text();
        foreach (text[i])
            send_char(text[i]);
        send_char(CH_NUL);
        text.delete();
    endtask

    task automatic send_field(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_text();
    endtask

    // Holds the sender until every expected result is in, then lets the
    // pipeline settle.
    task automatic wait_for_results();
        chr.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic configure(input logic [2:0] int_lim, input logic [2:0] frac_lim);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_INT_LIMIT;
        i_cfg_data  <= int_lim;
        @(negedge i_clk);
        i_cfg_index <= REG_FRAC_LIMIT;
        i_cfg_data  <= frac_lim;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.int_limit  = int_lim;
        sb.frac_limit = frac_lim;
    endtask

    function automatic int digit_run(input logic [2:0] lim);
        if ($urandom_range(0, 9) < 7)
            return int'($urandom_range(0, int'(lim) + 1));
        return int'($urandom_range(0, 17));
    endfunction

    function automatic void push_digits(input int n);
        for (int i = 0; i < n; i++)
            text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // Builds a number text: optional sign, integer digits (possibly none), optional fraction.
    function automatic void make_number();
        int sign_pick;
        sign_pick = $urandom_range(0, 2);
        if (sign_pick == 1)
            text.push_back(CH_PLUS);
        else if (sign_pick == 2)
            text.push_back(CH_MINUS);
        push_digits(digit_run(sb.int_limit));
        if ($urandom_range(0, 2) != 0) begin
            text.push_back(CH_DOT);
            push_digits(1 + digit_run(sb.frac_limit));
        end
    endfunction

    // Picks a random field: mostly numbers, some broken, some bare noise.
    task automatic send_random_field();
        int           kind;
        logic [7:0]   odd;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            make_number();
        end else if (kind < 80) begin
            // One stray character inserted somewhere in a built number.
            make_number();
            case ($urandom_range(0, 3))
                0: odd = CH_DOT;
                1: odd = CH_PLUS;
                2: odd = CH_MINUS;
                default: odd = 8'($urandom_range(1, 255));
            endcase
            text.insert($urandom_range(0, text.size()), odd);
        end else if (kind < 90) begin
            case ($urandom_range(0, 4))
                0: ;
                1: text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                2: begin
                    push_digits($urandom_range(1, 4));
                    text.push_back(CH_DOT);
                end
                3: begin
                    text.push_back(CH_DOT);
                    push_digits($urandom_range(0, 3));
                end
                default: begin
                    text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    text.push_back(CH_DOT);
                    push_digits($urandom_range(0, 3));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 6))
                text.push_back(8'($urandom_range(1, 255)));
        end
        send_text();
    endtask

    initial begin
        logic [2:0] int_set[PHASES];
        logic [2:0] frac_set[PHASES];
        int_set  = '{3'd7, 3'd1, 3'd0, 3'd7, 3'd3, 3'd0};
        frac_set = '{3'd7, 3'd1, 3'd7, 3'd0, 3'd5, 3'd0};
        int_set[PHASES-1]  = 3'($urandom_range(0, 7));
        frac_set[PHASES-1] = 3'($urandom_range(0, 7));

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_INT_LIMIT;
        i_cfg_data    = '0;
        chr.valid     = 1'b0;
        chr.char_code = '0;
        res.ready     = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed fields at the reset limits.
        send_field("");
        send_field("-");
        send_field(".");
        send_field("+.");
        send_field("7.");
        send_field("-9.09");
        send_field("1a");
        send_field("\377");

        // Random phases, each under its own pair of digit limits.
        sent_chars = 0;
        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            configure(int_set[p], frac_set[p]);
            steady = (p == 4);
            while (sent_chars < (p + 1) * RANDOM_CHARS / PHASES)
                send_random_field();
        end
        steady = 1'b0;

        wait_for_results();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Ends a run that hangs.
    initial begin
        #400000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
